// File: src/kcd_pkg.sv
// Shared types and constants for the KISS command deframer.
`default_nettype none
package kcd_pkg;

    localparam int unsigned LEN_W = 11;

    localparam logic [7:0] KISS_FEND   = 8'hC0;
    localparam logic [7:0] KISS_FESC   = 8'hDB;
    localparam logic [7:0] KISS_TFEND  = 8'hDC;
    localparam logic [7:0] KISS_TFESC  = 8'hDD;
    localparam logic [7:0] KISS_NO_CMD = 8'hFE;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(600);

    typedef enum logic {
        KIND_PAYLOAD   = 1'b0,
        KIND_FRAME_END = 1'b1
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
    } t_in_beat;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       command;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] position;
        logic             truncated;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_result_slot;

endpackage
`default_nettype wire

// File: src/kcd_stream_if.sv
// Valid/ready channel carrying one payload beat.
`default_nettype none
interface kcd_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: src/kiss_command_deframer_top.sv
// Top level of the KISS command deframer.
// One raw serial byte per input beat; each beat yields at most one result beat: an unescaped
// payload byte with its index, or a frame-complete beat carrying the command, the kept payload
// length and a truncation flag. The block takes one byte per cycle unless the output stalls,
// passing each input beat through an input register, then the decode and framing-state update
// in one step into the result register. A stall on the output holds both stages; the input
// side keeps taking beats while the result register is free or drains in the same cycle.
// The payload limit is written over the config channel, which is always ready, and should be
// changed only while no bytes are in flight.
`default_nettype none
module kiss_command_deframer_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    kcd_stream_if.sink   i_in_ch,
    kcd_stream_if.sink   i_cfg_ch,
    kcd_stream_if.source o_out_ch
);
    import kcd_pkg::*;

    logic [LEN_W-1:0] r_max_len;
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    t_result          r_out_data;

    logic         advance;
    t_result_slot dec_result;
    t_in_beat     in_beat;

    assign in_beat = i_in_ch.payload;

    // the decode stage moves whenever the result register can take its beat
    assign advance        = !r_out_valid || o_out_ch.ready;
    assign i_in_ch.ready  = !r_in_valid || advance;
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_ch.valid) begin
            r_max_len <= i_cfg_ch.payload[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.ready && i_in_ch.valid) begin
            r_in_byte <= in_beat.in_byte;
        end
    end

    kcd_decoder u_decoder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (r_in_valid && advance),
        .i_byte    (r_in_byte),
        .i_max_len (r_max_len),
        .o_result  (dec_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= dec_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && dec_result.valid) begin
            r_out_data <= dec_result.data;
        end
    end

    assign o_out_ch.valid   = r_out_valid;
    assign o_out_ch.payload = r_out_data;

endmodule
`default_nettype wire

// File: src/kcd_decoder.sv
// Framing state and per-byte KISS decode.
`default_nettype none
module kcd_decoder (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_step,
    input  wire  [7:0]                i_byte,
    input  wire  [kcd_pkg::LEN_W-1:0] i_max_len,
    output kcd_pkg::t_result_slot     o_result
);
    import kcd_pkg::*;

    logic             r_inside, n_inside;
    logic             r_escape, n_escape;
    logic [7:0]       r_command, n_command;
    logic [LEN_W-1:0] r_count, n_count;
    logic             r_overflow, n_overflow;

    logic [7:0] data_mapped;

    always_comb begin
        case (i_byte)
            KISS_TFEND: data_mapped = KISS_FEND;
            KISS_TFESC: data_mapped = KISS_FESC;
            default:    data_mapped = i_byte;
        endcase
        if (!r_escape) begin
            data_mapped = i_byte;
        end
    end

    always_comb begin
        n_inside   = r_inside;
        n_escape   = r_escape;
        n_command  = r_command;
        n_count    = r_count;
        n_overflow = r_overflow;
        o_result   = '0;

        if (i_byte == KISS_FEND) begin
            // shared delimiter: close a frame that has a command, open the next
            if (r_inside && r_command != KISS_NO_CMD) begin
                o_result.valid          = 1'b1;
                o_result.data.kind      = KIND_FRAME_END;
                o_result.data.command   = r_command;
                o_result.data.position  = r_count;
                o_result.data.truncated = r_overflow;
            end
            n_inside   = 1'b1;
            n_escape   = 1'b0;
            n_command  = KISS_NO_CMD;
            n_count    = '0;
            n_overflow = 1'b0;
        end else if (!r_inside) begin
            // noise before the first delimiter
        end else if (r_command == KISS_NO_CMD) begin
            n_command = i_byte;
        end else if (i_byte == KISS_FESC) begin
            n_escape = 1'b1;
        end else begin
            n_escape = 1'b0;
            if (r_count < i_max_len) begin
                o_result.valid          = 1'b1;
                o_result.data.kind      = KIND_PAYLOAD;
                o_result.data.command   = r_command;
                o_result.data.data_byte = data_mapped;
                o_result.data.position  = r_count;
                n_count                 = r_count + LEN_W'(1);
            end else begin
                n_overflow = 1'b1;
            end
        end

        if (!i_step) begin
            o_result.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside   <= 1'b0;
            r_escape   <= 1'b0;
            r_command  <= KISS_NO_CMD;
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else if (i_step) begin
            r_inside   <= n_inside;
            r_escape   <= n_escape;
            r_command  <= n_command;
            r_count    <= n_count;
            r_overflow <= n_overflow;
        end
    end

endmodule
`default_nettype wire
